### hdl/hse_pkg.sv
// shared item types for the heap sort engine
`default_nettype none

package hse_pkg;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} load_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               final_res;
	} sort_item_t;

	localparam int unsigned DATA_W = 32;

endpackage

`default_nettype wire

### hdl/hse_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
`default_nettype none

module hse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/heap_sort_engine.sv
// heap sort engine: collects signed values, heap-sorts them and emits them ascending
//
// load channel: one value per item, accepted while the engine is idle; items
// beyond MAX_ELEMENTS are dropped. an item with last set closes the set and
// starts the sort; load_stall stays high until the last sorted item has been
// placed in the output register.
// sort: builds a max-heap, then moves the root to the end n-1 times. every sift
// level reads the left and then the right child on the single read port of the
// element ram, then compares and writes back; a build sift first reads the value
// to sift, an extraction first moves the root out to the end of the heap.
// emission: each element is read from the ram and loaded into the output register,
// which must drain before the next element is loaded, so emission slows while the
// receiver holds sort_stall high; the output register keeps its item until taken,
// and the engine accepts the next set while the final item waits.
// reset clears the element count and the control state; ram contents are only
// read after they have been written for the current set.
`default_nettype none

module heap_sort_engine #(
	parameter int MAX_ELEMENTS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load_valid,
	output logic                    load_stall,
	input  wire hse_pkg::load_item_t load_item,
	output logic                    sort_valid,
	input  wire logic               sort_stall,
	output hse_pkg::sort_item_t     sort_item
);

	localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int CW    = ((AW + 2) > CNT_W) ? (AW + 2) : CNT_W;
	localparam int DW    = hse_pkg::DATA_W;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SV   = 11'b000_0000_0010,
		ST_SVG  = 11'b000_0000_0100,
		ST_SL   = 11'b000_0000_1000,
		ST_SR   = 11'b000_0001_0000,
		ST_SC   = 11'b000_0010_0000,
		ST_XA   = 11'b000_0100_0000,
		ST_XB   = 11'b000_1000_0000,
		ST_XC   = 11'b001_0000_0000,
		ST_ERD  = 11'b010_0000_0000,
		ST_ELD  = 11'b100_0000_0000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       k_q;
	logic [CNT_W-1:0]       heap_q;
	logic [AW-1:0]          node_q;
	logic                   extract_q;
	logic signed [DW-1:0]   v_q;
	logic signed [DW-1:0]   lv_q;
	logic                   res_valid_q;
	hse_pkg::sort_item_t    res_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [DW-1:0]          ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [DW-1:0]          ram_rdata;

	logic                   load_acc;
	logic                   has_room;
	logic [CNT_W-1:0]       n_new;
	logic [CNT_W-1:0]       half;
	logic [CW-1:0]          lc;
	logic [CW-1:0]          rc;
	logic [CW-1:0]          heap_ext;
	logic                   lc_ok;
	logic                   rc_ok;
	logic                   pick_r;
	logic signed [DW-1:0]   big_v;
	logic [AW-1:0]          big_idx;
	logic                   move_up;
	logic                   sift_done;
	logic                   is_final;

	hse_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ELEMENTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign load_stall = (state_q != ST_IDLE);
	assign load_acc   = load_valid && !load_stall;
	assign has_room   = (count_q < CNT_W'(MAX_ELEMENTS));
	assign n_new      = has_room ? CNT_W'(count_q + 1'b1) : count_q;
	assign half       = n_new >> 1;

	assign lc       = CW'({node_q, 1'b1});
	assign rc       = CW'(lc + 1'b1);
	assign heap_ext = CW'(heap_q);
	assign lc_ok    = (lc < heap_ext);
	assign rc_ok    = (rc < heap_ext);

	// right child wins only when present and strictly larger
	assign pick_r  = rc_ok && ($signed(ram_rdata) > lv_q);
	assign big_v   = pick_r ? $signed(ram_rdata) : lv_q;
	assign big_idx = pick_r ? rc[AW-1:0] : lc[AW-1:0];
	assign move_up = (big_v > v_q);

	assign sift_done = ((state_q == ST_SL) && !lc_ok) || ((state_q == ST_SC) && !move_up);
	assign is_final  = (CNT_W'(k_q + 1'b1) == count_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = v_q;
		ram_raddr = node_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_we    = load_acc && has_room;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = load_item.value;
			end
			ST_SL: begin
				ram_raddr = lc[AW-1:0];
				ram_we    = !lc_ok;
			end
			ST_SR: begin
				ram_raddr = rc[AW-1:0];
			end
			ST_SC: begin
				ram_we    = 1'b1;
				ram_wdata = move_up ? big_v : v_q;
			end
			ST_XA: begin
				ram_raddr = AW'(k_q - 1'b1);
			end
			ST_XB: begin
				ram_raddr = '0;
			end
			ST_XC: begin
				// root goes to the end of the shrinking heap
				ram_we    = 1'b1;
				ram_waddr = AW'(k_q - 1'b1);
				ram_wdata = ram_rdata;
			end
			ST_ERD: begin
				ram_raddr = k_q[AW-1:0];
			end
			ST_SV, ST_SVG, ST_ELD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			heap_q      <= '0;
			node_q      <= '0;
			extract_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !sort_stall) begin
				res_valid_q <= 1'b0;
			end
			if (sift_done) begin
				if (!extract_q && (k_q > CNT_W'(1))) begin
					k_q     <= CNT_W'(k_q - 1'b1);
					node_q  <= AW'(k_q - CNT_W'(2));
					state_q <= ST_SV;
				end else if (!extract_q) begin
					extract_q <= 1'b1;
					k_q       <= count_q;
					state_q   <= ST_XA;
				end else if (k_q > CNT_W'(2)) begin
					k_q     <= CNT_W'(k_q - 1'b1);
					state_q <= ST_XA;
				end else begin
					k_q     <= '0;
					state_q <= ST_ERD;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (load_acc) begin
							count_q <= n_new;
							if (load_item.last) begin
								extract_q <= 1'b0;
								heap_q    <= n_new;
								if (half != '0) begin
									k_q     <= half;
									node_q  <= AW'(half - 1'b1);
									state_q <= ST_SV;
								end else begin
									k_q     <= '0;
									state_q <= ST_ERD;
								end
							end
						end
					end
					ST_SV: begin
						state_q <= ST_SVG;
					end
					ST_SVG: begin
						state_q <= ST_SL;
					end
					ST_SL: begin
						state_q <= ST_SR;
					end
					ST_SR: begin
						state_q <= ST_SC;
					end
					ST_SC: begin
						node_q  <= big_idx;
						state_q <= ST_SL;
					end
					ST_XA: begin
						state_q <= ST_XB;
					end
					ST_XB: begin
						state_q <= ST_XC;
					end
					ST_XC: begin
						node_q  <= '0;
						heap_q  <= CNT_W'(k_q - 1'b1);
						state_q <= ST_SL;
					end
					ST_ERD: begin
						// wait until the output register is free
						if (!res_valid_q) begin
							state_q <= ST_ELD;
						end
					end
					ST_ELD: begin
						res_valid_q <= 1'b1;
						k_q         <= CNT_W'(k_q + 1'b1);
						if (is_final) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ERD;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// sifted value, left child value and output item, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_SVG || state_q == ST_XB) begin
			v_q <= $signed(ram_rdata);
		end
		if (state_q == ST_SR) begin
			lv_q <= $signed(ram_rdata);
		end
		if (state_q == ST_ELD) begin
			res_q.sorted_value <= $signed(ram_rdata);
			res_q.final_res    <= is_final;
		end
	end

	assign sort_valid = res_valid_q;
	assign sort_item  = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count above capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELD) |-> !res_valid_q)
		else $error("output register loaded while still occupied");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_ELD))
		else $error("result raised outside emission");

	a_node_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SL) |-> (CW'(node_q) < heap_ext))
		else $error("sift position beyond heap");

endmodule

`default_nettype wire

### dv/heap_sort_checker.sv
// checker for the heap sort engine: mirrors the load channel, sorts each set and compares output items
`timescale 1ns / 1ps

module heap_sort_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  logic                load_stall,
	input  hse_pkg::load_item_t load_item,
	input  logic                sort_valid,
	input  logic                sort_stall,
	input  hse_pkg::sort_item_t sort_item,
	output int                  mismatches,
	output int                  pending,
	output int                  sets_sorted,
	output int                  results_checked
);

	logic signed [31:0]  held_values [64];
	int unsigned         held_count;
	hse_pkg::sort_item_t ascending_q [$];

	initial begin
		mismatches      = 0;
		pending         = 0;
		sets_sorted     = 0;
		results_checked = 0;
		held_count      = 0;
	end

	task report_mismatch(input string what);
		if (mismatches < 40) begin
			$display("mismatch at %0t ns: %s", $time, what);
		end
		mismatches++;
	endtask

	// push the entry at top down until no child is larger
	task automatic sink_node(input int unsigned size, input int unsigned top);
		int unsigned        node;
		int unsigned        lc;
		int unsigned        rc;
		int unsigned        big;
		logic signed [31:0] tmp;
		bit                 settled;
		node    = top;
		settled = 0;
		while (!settled) begin
			lc  = 2 * node + 1;
			rc  = 2 * node + 2;
			big = node;
			if (lc < size && held_values[lc] > held_values[big]) begin
				big = lc;
			end
			if (rc < size && held_values[rc] > held_values[big]) begin
				big = rc;
			end
			if (big == node) begin
				settled = 1;
			end else begin
				tmp               = held_values[node];
				held_values[node] = held_values[big];
				held_values[big]  = tmp;
				node              = big;
			end
		end
	endtask

	// max-heap build, then repeated root extraction to the end
	task automatic heap_sort_held(input int unsigned n);
		int unsigned        k;
		logic signed [31:0] tmp;
		for (k = n / 2; k > 0; k--) begin
			sink_node(n, k - 1);
		end
		for (k = n; k > 1; k--) begin
			tmp                = held_values[0];
			held_values[0]     = held_values[k - 1];
			held_values[k - 1] = tmp;
			sink_node(k - 1, 0);
		end
	endtask

	always @(posedge clk) begin
		hse_pkg::sort_item_t want;
		int unsigned         k;
		if (arst_n) begin
			if (load_valid && !load_stall) begin
				if (held_count < CAPACITY) begin
					held_values[held_count] = load_item.value;
					held_count++;
				end
				if (load_item.last) begin
					heap_sort_held(held_count);
					for (k = 0; k < held_count; k++) begin
						want.sorted_value = held_values[k];
						want.final_res    = (k + 1 == held_count);
						ascending_q.push_back(want);
					end
					held_count = 0;
					sets_sorted++;
				end
			end
			if (sort_valid && !sort_stall) begin
				results_checked++;
				if (ascending_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item value %0d final %0b",
						sort_item.sorted_value, sort_item.final_res));
				end else begin
					want = ascending_q.pop_front();
					if (sort_item.sorted_value !== want.sorted_value) begin
						report_mismatch($sformatf("sorted_value %0d, expected %0d",
							sort_item.sorted_value, want.sorted_value));
					end
					if (sort_item.final_res !== want.final_res) begin
						report_mismatch($sformatf("final_res %0b, expected %0b (value %0d)",
							sort_item.final_res, want.final_res, want.sorted_value));
					end
				end
			end
			pending = ascending_q.size();
		end
	end

endmodule

### dv/heap_sort_engine_tb.sv
// testbench top for the heap sort engine: clock, reset, load and sort channel stimulus, verdict
`timescale 1ns / 1ps

module heap_sort_engine_tb;

	localparam int CAPACITY  = 64;
	localparam int LONG_HOLD = 3000;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                load_valid  = 1'b0;
	logic                load_stall;
	hse_pkg::load_item_t load_item   = '0;
	logic                sort_valid;
	logic                sort_stall  = 1'b0;
	hse_pkg::sort_item_t sort_item;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  long_hold_req = 0;
	bit  long_hold_done = 0;
	int  hold_left = 0;
	int  items_offered = 0;

	int  mismatches;
	int  pending;
	int  sets_sorted;
	int  results_checked;

	heap_sort_engine #(
		.MAX_ELEMENTS(CAPACITY)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(load_valid),
		.load_stall(load_stall),
		.load_item (load_item),
		.sort_valid(sort_valid),
		.sort_stall(sort_stall),
		.sort_item (sort_item)
	);

	heap_sort_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.load_valid     (load_valid),
		.load_stall     (load_stall),
		.load_item      (load_item),
		.sort_valid     (sort_valid),
		.sort_stall     (sort_stall),
		.sort_item      (sort_item),
		.mismatches     (mismatches),
		.pending        (pending),
		.sets_sorted    (sets_sorted),
		.results_checked(results_checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random stall, plus one long hold so the engine backs up
	always @(posedge clk) begin
		if (long_hold_req && !long_hold_done) begin
			long_hold_done <= 1;
			hold_left      <= LONG_HOLD;
			sort_stall     <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left  <= hold_left - 1;
			sort_stall <= 1'b1;
		end else begin
			sort_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task send_item(input logic signed [31:0] value, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			load_valid <= 1'b0;
			@(posedge clk);
		end
		load_valid      <= 1'b1;
		load_item.value <= value;
		load_item.last  <= last;
		items_offered++;
		@(posedge clk);
		while (load_stall) begin
			@(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return $urandom_range(0, 1) ? 32'sh0 : -32'sd1;
			3, 4, 5: return $signed($urandom_range(0, 16)) - 32'sd8;
			default: return $signed($urandom);
		endcase
	endfunction

	task send_random_set(input int size);
		int i;
		for (i = 0; i < size; i++) begin
			send_item(pick_value(), i == size - 1);
		end
	endtask

	function automatic int pick_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return $urandom_range(1, 12);
		if (roll < 92) return $urandom_range(13, 63);
		if (roll < 96) return CAPACITY;
		return $urandom_range(CAPACITY + 1, CAPACITY + 8);
	endfunction

	initial begin
		int phase;
		int i;
		int phase_end;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct <= 20;
		recv_idle_pct <= 55;

		// single element at the top of the range
		send_item(32'sh7fff_ffff, 1'b1);
		// extremes with duplicates mixed in
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh0, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(32'sd1, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh7fff_ffff, 1'b1);
		// all equal
		for (i = 0; i < 4; i++) begin
			send_item(32'sd5, i == 3);
		end
		// already ascending, then descending
		for (i = 0; i < 6; i++) begin
			send_item(i - 2, i == 5);
		end
		for (i = 0; i < 6; i++) begin
			send_item(32'sd1000 - i * 300, i == 5);
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct <= 20;
					recv_idle_pct <= 55;
				end
				1: begin
					send_idle_pct <= 55;
					recv_idle_pct <= 20;
				end
				default: begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
				end
			endcase
			phase_end = items_offered + 100;
			if (phase == 2) begin
				// full store, then overflow, while the receiver holds off
				long_hold_req <= 1;
				send_random_set(CAPACITY);
				send_random_set(CAPACITY + 3);
			end else begin
				send_random_set(CAPACITY + 1);
			end
			while (items_offered < phase_end) begin
				send_random_set(pick_size());
			end
		end
		load_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);

		$display("covered %0d load items in %0d sets, %0d sorted items checked",
			items_offered, sets_sorted, results_checked);
		$display("sets from 1 element to overflow past %0d, under three idle mixes and a long hold",
			CAPACITY);
		if (mismatches == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("timeout with %0d items still expected", pending);
		$display("status: fail");
		$finish;
	end

endmodule

### files.f
hdl/hse_pkg.sv
hdl/hse_ram.sv
hdl/heap_sort_engine.sv
dv/heap_sort_checker.sv
dv/heap_sort_engine_tb.sv
